// ----- rtl/mprt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprt_pkg
// Shared types and constants for the memory region permission table.
// ----------------------------------------------------------------------------
package mprt_pkg;

    // Table geometry
    localparam int REGIONS = 64;
    localparam int IDX_W   = $clog2(REGIONS);

    // Field widths
    localparam int ADDR_W = 64;
    localparam int LEN_W  = 32;
    localparam int PERM_W = 3;

    // Permission bits
    localparam logic [PERM_W-1:0] PERM_READ  = 3'b001;
    localparam logic [PERM_W-1:0] PERM_WRITE = 3'b010;
    localparam logic [PERM_W-1:0] PERM_EXEC  = 3'b100;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_EXEC  = 2'd2,
        OP_CLEAR = 2'd3
    } mprt_op_t;

    // Status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Merge kinds
    localparam logic [1:0] MK_NEW   = 2'd0;
    localparam logic [1:0] MK_END   = 2'd1;
    localparam logic [1:0] MK_START = 2'd2;
    localparam logic [1:0] MK_NONE  = 2'd3;

    // Search key held for the length of one table walk
    typedef struct packed {
        logic [ADDR_W-1:0] lo;       // range start
        logic [ADDR_W-1:0] hi;       // inclusive range end
        logic [ADDR_W-1:0] lo_m1;    // lo - 1, left neighbor end
        logic [ADDR_W-1:0] hi_p1;    // hi + 1 for an add, right neighbor start
        logic              lo_nz;    // a left neighbor can exist
        logic              hi_nmax;  // a right neighbor can exist
        logic [PERM_W-1:0] perm;     // permissions of the range
    } mprt_key_t;

    // Per-entry match flags
    typedef struct packed {
        logic overlap;  // entry intersects [lo, hi]
        logic left;     // entry ends at lo - 1 with equal permissions
        logic right;    // entry starts at hi + 1 with equal permissions
    } mprt_match_t;

endpackage

// ----- rtl/memory_region_permission_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_region_permission_table_top
// Region table with add, readable-range test, execute test and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: operation, address,
//   last_address, length, prot_bits. Output channel (out_valid/out_ready)
//   returns one result item per input item: status, granted, covered_bytes,
//   merge_kind.
//   Add and both tests walk the whole table, one entry per cycle through the
//   single compare unit and the one read port of the entry memory. After
//   acceptance an add or test passes through S_SCAN, S_DRAIN and S_FINISH,
//   where its result is loaded; a clear goes straight to S_FINISH. in_ready
//   is high only while the block is idle, so a new item is taken only after
//   the previous item's result has been loaded.
//   The result sits in an output register; if the receiver stalls, the block
//   holds the finished item in its last step and accepts nothing new until
//   the result is taken. Table updates land when the result is loaded.
//   Reset empties the table (valid bits clear at once, no sweep) and drops
//   any item in progress. Entry contents are not reset.
// ----------------------------------------------------------------------------
module memory_region_permission_table_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        operation,
    input  logic [mprt_pkg::ADDR_W-1:0]       address,
    input  logic [mprt_pkg::ADDR_W-1:0]       last_address,
    input  logic [mprt_pkg::LEN_W-1:0]        length,
    input  logic [mprt_pkg::PERM_W-1:0]       prot_bits,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic                              granted,
    output logic [mprt_pkg::LEN_W-1:0]        covered_bytes,
    output logic [1:0]                        merge_kind
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    localparam int AW = mprt_pkg::ADDR_W;
    localparam int LW = mprt_pkg::LEN_W;
    localparam int PW = mprt_pkg::PERM_W;
    localparam int IW = mprt_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(mprt_pkg::REGIONS - 1);

    // Entry memory
    logic [AW-1:0] start_mem [mprt_pkg::REGIONS];
    logic [AW-1:0] end_mem   [mprt_pkg::REGIONS];
    logic [PW-1:0] perm_mem  [mprt_pkg::REGIONS];
    logic [AW-1:0] rd_start_reg;
    logic [AW-1:0] rd_end_reg;
    logic [PW-1:0] rd_perm_reg;

    // Control and walk state
    state_t                 state_reg;
    mprt_pkg::mprt_op_t     op_reg;
    mprt_pkg::mprt_key_t    key_reg;
    mprt_pkg::mprt_key_t    key_next;
    logic [LW-1:0]          len_reg;
    logic [IW-1:0]          idx_reg;
    logic                   look_reg;
    logic [IW-1:0]          look_idx_reg;
    logic [mprt_pkg::REGIONS-1:0] valid_reg;

    // Walk results
    logic                   ovl_reg;
    logic [AW-1:0]          hit_end_reg;
    logic [PW-1:0]          hit_perm_reg;
    logic                   left_found_reg;
    logic [IW-1:0]          left_idx_reg;
    logic                   right_found_reg;
    logic [IW-1:0]          right_idx_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;

    // Output registers
    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic                   granted_reg;
    logic [LW-1:0]          cov_reg;
    logic [1:0]             merge_reg;

    mprt_pkg::mprt_match_t  match;

    // Finish-step decisions
    logic                   fire;
    logic                   add_reject;
    logic                   do_left;
    logic                   do_right;
    logic                   do_new;
    logic [AW-1:0]          rem;
    logic [LW-1:0]          cov;
    logic                   rd_ok;
    logic [1:0]             status_next;
    logic                   granted_next;
    logic [LW-1:0]          cov_next;
    logic [1:0]             merge_next;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted       = granted_reg;
    assign covered_bytes = cov_reg;
    assign merge_kind    = merge_reg;

    // Search key from the incoming item; tests use a single-point range
    always_comb
    begin
        key_next.lo      = address;
        key_next.hi      = (mprt_pkg::mprt_op_t'(operation) == mprt_pkg::OP_ADD)
                           ? last_address : address;
        key_next.lo_m1   = address - AW'(1);
        key_next.hi_p1   = last_address + AW'(1);
        key_next.lo_nz   = (address != '0);
        key_next.hi_nmax = (last_address != '1);
        key_next.perm    = prot_bits;
    end

    // Compare unit shared by every step of the walk
    mprt_match u_match (
        .ent_valid (valid_reg[look_idx_reg]),
        .ent_start (rd_start_reg),
        .ent_end   (rd_end_reg),
        .ent_perm  (rd_perm_reg),
        .key       (key_reg),
        .match     (match)
    );

    // Result and table update decisions
    always_comb
    begin
        fire       = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
        add_reject = ovl_reg || (key_reg.hi < key_reg.lo);
        do_left    = !add_reject && left_found_reg;
        do_right   = !add_reject && !left_found_reg && right_found_reg;
        do_new     = !add_reject && !left_found_reg && !right_found_reg && free_found_reg;

        rem   = hit_end_reg - key_reg.lo + AW'(1);
        cov   = (rem < {{(AW-LW){1'b0}}, len_reg}) ? rem[LW-1:0] : len_reg;
        rd_ok = (len_reg != '0) && key_reg.lo_nz && ovl_reg
                && ((hit_perm_reg & mprt_pkg::PERM_READ) != '0);

        status_next  = mprt_pkg::ST_DONE;
        granted_next = 1'b0;
        cov_next     = '0;
        merge_next   = mprt_pkg::MK_NONE;
        case (op_reg)
            mprt_pkg::OP_ADD:
            begin
                if (add_reject)
                    status_next = mprt_pkg::ST_REJECT;
                else if (do_left)
                    merge_next = mprt_pkg::MK_END;
                else if (do_right)
                    merge_next = mprt_pkg::MK_START;
                else if (do_new)
                    merge_next = mprt_pkg::MK_NEW;
                else
                    status_next = mprt_pkg::ST_FULL;
            end
            mprt_pkg::OP_READ:
            begin
                if (rd_ok)
                begin
                    cov_next     = cov;
                    granted_next = (cov == len_reg);
                end
            end
            mprt_pkg::OP_EXEC:
            begin
                granted_next = ovl_reg && ((hit_perm_reg & mprt_pkg::PERM_EXEC) != '0);
            end
            default:
            begin
                status_next = mprt_pkg::ST_DONE;
            end
        endcase
    end

    // Entry memory: one read per cycle at the walk index, writes at finish
    always_ff @(posedge clk)
    begin
        rd_start_reg <= start_mem[idx_reg];
        rd_end_reg   <= end_mem[idx_reg];
        rd_perm_reg  <= perm_mem[idx_reg];
        if (fire && (op_reg == mprt_pkg::OP_ADD))
        begin
            if (do_left)
                end_mem[left_idx_reg] <= key_reg.hi;
            else if (do_right)
                start_mem[right_idx_reg] <= key_reg.lo;
            else if (do_new)
            begin
                start_mem[free_idx_reg] <= key_reg.lo;
                end_mem[free_idx_reg]   <= key_reg.hi;
                perm_mem[free_idx_reg]  <= key_reg.perm;
            end
        end
    end

    // Sequencer, walk accumulators, valid bits and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= mprt_pkg::ST_DONE;
            granted_reg     <= 1'b0;
            cov_reg         <= '0;
            merge_reg       <= mprt_pkg::MK_NONE;
            look_reg        <= 1'b0;
            idx_reg         <= '0;
            look_idx_reg    <= '0;
            op_reg          <= mprt_pkg::OP_ADD;
            key_reg         <= '0;
            len_reg         <= '0;
            ovl_reg         <= 1'b0;
            hit_end_reg     <= '0;
            hit_perm_reg    <= '0;
            left_found_reg  <= 1'b0;
            left_idx_reg    <= '0;
            right_found_reg <= 1'b0;
            right_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
        end
        else
        begin
            // result taken and no new one loaded this cycle
            if (out_valid_reg && out_ready && !fire)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg          <= mprt_pkg::mprt_op_t'(operation);
                        key_reg         <= key_next;
                        len_reg         <= length;
                        idx_reg         <= '0;
                        look_reg        <= 1'b0;
                        ovl_reg         <= 1'b0;
                        left_found_reg  <= 1'b0;
                        right_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        if (mprt_pkg::mprt_op_t'(operation) == mprt_pkg::OP_CLEAR)
                            state_reg <= S_FINISH;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    look_reg     <= 1'b1;
                    look_idx_reg <= idx_reg;
                    idx_reg      <= idx_reg + IW'(1);
                    if (idx_reg == LAST_IDX)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    look_reg  <= 1'b0;
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (fire)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= status_next;
                        granted_reg   <= granted_next;
                        cov_reg       <= cov_next;
                        merge_reg     <= merge_next;
                        if (op_reg == mprt_pkg::OP_CLEAR)
                            valid_reg <= '0;
                        else if ((op_reg == mprt_pkg::OP_ADD) && do_new)
                            valid_reg[free_idx_reg] <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Accumulate the entry read in the previous cycle
            if (look_reg && ((state_reg == S_SCAN) || (state_reg == S_DRAIN)))
            begin
                if (match.overlap)
                begin
                    ovl_reg      <= 1'b1;
                    hit_end_reg  <= rd_end_reg;
                    hit_perm_reg <= rd_perm_reg;
                end
                if (match.left && !left_found_reg)
                begin
                    left_found_reg <= 1'b1;
                    left_idx_reg   <= look_idx_reg;
                end
                if (match.right && !right_found_reg)
                begin
                    right_found_reg <= 1'b1;
                    right_idx_reg   <= look_idx_reg;
                end
                if (!valid_reg[look_idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= look_idx_reg;
                end
            end
        end
    end

endmodule

// ----- rtl/mprt_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mprt_match
// Shared compare unit: checks one table entry against the search key.
// ----------------------------------------------------------------------------
module mprt_match (
    input  logic                          ent_valid,
    input  logic [mprt_pkg::ADDR_W-1:0]   ent_start,
    input  logic [mprt_pkg::ADDR_W-1:0]   ent_end,
    input  logic [mprt_pkg::PERM_W-1:0]   ent_perm,
    input  mprt_pkg::mprt_key_t           key,
    output mprt_pkg::mprt_match_t         match
);

    logic perm_eq;

    assign perm_eq = (ent_perm == key.perm);

    // Interval intersection and neighbor adjacency
    always_comb
    begin
        match.overlap = ent_valid && (ent_start <= key.hi) && (key.lo <= ent_end);
        match.left    = ent_valid && key.lo_nz && (ent_end == key.lo_m1) && perm_eq;
        match.right   = ent_valid && key.hi_nmax && (ent_start == key.hi_p1) && perm_eq;
    end

endmodule
